>>> rtl/bhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and constants for the binary heap priority queue: heap
// order selection, request codes, result status codes and fixed port widths.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  // Which key the root holds
  typedef enum logic {
    ORDER_MIN = 1'b0,
    ORDER_MAX = 1'b1
  } order_t;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage
`default_nettype wire

>>> rtl/bhpq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/bhpq_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_cmp
// Shared key comparator: flags when key a belongs nearer the root than b
// under the selected heap order.
// ----------------------------------------------------------------------------
module bhpq_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  wire bhpq_pkg::order_t        mode,
  input  wire logic [KEY_WIDTH-1:0]    key_a,
  input  wire logic [KEY_WIDTH-1:0]    key_b,
  output logic                         a_better
);
  import bhpq_pkg::*;

  logic signed [KEY_WIDTH-1:0] sa;
  logic signed [KEY_WIDTH-1:0] sb;

  assign sa = $signed(key_a);
  assign sb = $signed(key_b);

  always_comb begin
    unique case (mode)
      ORDER_MAX: a_better = (sa > sb);
      ORDER_MIN: a_better = (sa < sb);
      default:   a_better = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/binary_heap_priority_queue.sv
`default_nettype none
// A refused beat goes straight to the result. An insert reads the parent and compares
// for each level it climbs; a remove reads the root and the last entry, stops there
// if it empties the queue, else for each level it sinks reads the left and right
// children, picks one and swaps. The next beat is taken the cycle after the result loads.
// Reset (rst, synchronous): empty queue, largest-at-root order; RAM not cleared.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Array-backed binary heap with insert and remove-root, sifting through one
// single-write, single-read RAM and one shared comparator under a small sequencer.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write_en,
  input  wire logic                                  cfg_write_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  action,
  input  wire logic signed [bhpq_pkg::VALUE_W-1:0]   value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [bhpq_pkg::VALUE_W-1:0]        removed_value,
  output logic        [bhpq_pkg::STATUS_W-1:0]       status,
  output logic        [bhpq_pkg::COUNT_W-1:0]        entry_count
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_RD    = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_RM_ROOT  = 4'd3;
  localparam logic [3:0] S_RM_LAST  = 4'd4;
  localparam logic [3:0] S_RM_TAKE  = 4'd5;
  localparam logic [3:0] S_DN_LEFT  = 4'd6;
  localparam logic [3:0] S_DN_RIGHT = 4'd7;
  localparam logic [3:0] S_DN_PICK  = 4'd8;
  localparam logic [3:0] S_DN_SWAP  = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]           state, state_next;
  order_t               mode;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        pos, pos_next;
  logic [AW-1:0]        pick_pos, pick_pos_next;
  logic [KEY_WIDTH-1:0] hole_key, hole_key_next;
  logic [KEY_WIDTH-1:0] pick_key, pick_key_next;
  logic [VALUE_W-1:0]   rval, rval_next;
  logic [STATUS_W-1:0]  stat, stat_next;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_better;

  logic [63:0]          value_ext;
  logic [63:0]          rd_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [AW-1:0]        pos_m1;
  logic [AW-1:0]        parent;
  logic [LW-1:0]        left, right, count_x;
  logic [CW+COUNT_W-1:0] count_ext;
  logic                 out_load;

  assign value_ext = 64'(value);
  assign key_in    = value_ext[KEY_WIDTH-1:0];
  assign rd_ext    = 64'($signed(rd_data));
  assign pos_m1    = pos - 1'b1;
  assign parent    = pos_m1 >> 1;
  assign left      = {1'b0, pos, 1'b1};
  assign right     = left + 1'b1;
  assign count_x   = LW'(count);
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  bhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bhpq_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .mode     (mode),
    .key_a    (cmp_a),
    .key_b    (cmp_b),
    .a_better (cmp_better)
  );

  // Comparator operand steering
  always_comb begin
    unique case (state)
      S_UP_CMP: begin
        cmp_a = hole_key;
        cmp_b = rd_data;
      end
      S_DN_PICK: begin
        cmp_a = rd_data;
        cmp_b = pick_key;
      end
      default: begin
        cmp_a = pick_key;
        cmp_b = hole_key;
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    pick_pos_next = pick_pos;
    hole_key_next = hole_key;
    pick_key_next = pick_key;
    rval_next     = rval;
    stat_next     = stat;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = hole_key;
    rd_addr       = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rval_next = '0;
          stat_next = ST_OK;
          if (action == ACT_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              stat_next  = ST_FULL;
              state_next = S_DONE;
            end else begin
              hole_key_next = key_in;
              pos_next      = count[AW-1:0];
              count_next    = count + 1'b1;
              state_next    = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              stat_next  = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              count_next = count - 1'b1;
              state_next = S_RM_ROOT;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          rd_addr    = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_better) begin
          // move the parent down into the hole and climb
          wr_data    = rd_data;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end

      S_RM_ROOT: begin
        rd_addr    = '0;
        state_next = S_RM_LAST;
      end

      S_RM_LAST: begin
        // count already points at the last entry
        rd_addr   = count[AW-1:0];
        rval_next = rd_ext[VALUE_W-1:0];
        if (count == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RM_TAKE;
        end
      end

      S_RM_TAKE: begin
        hole_key_next = rd_data;
        pos_next      = '0;
        state_next    = S_DN_LEFT;
      end

      S_DN_LEFT: begin
        if (left >= count_x) begin
          wr_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          rd_addr    = left[AW-1:0];
          state_next = S_DN_RIGHT;
        end
      end

      S_DN_RIGHT: begin
        pick_key_next = rd_data;
        pick_pos_next = left[AW-1:0];
        if (right < count_x) begin
          rd_addr    = right[AW-1:0];
          state_next = S_DN_PICK;
        end else begin
          state_next = S_DN_SWAP;
        end
      end

      S_DN_PICK: begin
        // left wins ties
        if (cmp_better) begin
          pick_key_next = rd_data;
          pick_pos_next = right[AW-1:0];
        end
        state_next = S_DN_SWAP;
      end

      S_DN_SWAP: begin
        wr_en = 1'b1;
        if (cmp_better) begin
          wr_data    = pick_key;
          pos_next   = pick_pos;
          state_next = S_DN_LEFT;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= ORDER_MAX;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_write_en) begin
        mode <= order_t'(cfg_write_data);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    pick_pos <= pick_pos_next;
    hole_key <= hole_key_next;
    pick_key <= pick_key_next;
    rval     <= rval_next;
    stat     <= stat_next;
  end

  assign count_ext = (CW + COUNT_W)'(count);

  // Result beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      removed_value <= $signed(rval);
      status        <= stat;
      entry_count   <= count_ext[COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire
